// ===== rtl/dtl_pkg.sv =====
// ----------------------------------------------------------------------------
// dtl_pkg
// shared types and constants of the dusk timed light controller
// ----------------------------------------------------------------------------
package dtl_pkg;

  localparam int LevelW   = 10;
  localparam int MinuteW  = 11;
  localparam int DebW     = 4;
  localparam int DurW     = 9;
  localparam int TickW    = 16;
  localparam int PhaseW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_DARK_THR  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_THR = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ON_DUR    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_OFF_TIME  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_MAX_COOL  = 3'd5;

  localparam logic [LevelW-1:0]  RST_DARK_THR  = 10'd150;
  localparam logic [LevelW-1:0]  RST_LIGHT_THR = 10'd500;
  localparam logic [DebW-1:0]    RST_DEBOUNCE  = 4'd4;
  localparam int                 RST_ON_DUR    = 120;
  localparam logic [MinuteW-1:0] RST_OFF_TIME  = 11'd1380;
  localparam logic [TickW-1:0]   RST_MAX_COOL  = 16'd5400;

  localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
  localparam logic [PhaseW-1:0] PH_ON   = 2'd1;
  localparam logic [PhaseW-1:0] PH_COOL = 2'd2;

  localparam logic [DebW-1:0]  RUN_MAX  = '1;
  localparam logic [TickW-1:0] TICK_MAX = '1;

  typedef struct packed {
    logic [LevelW-1:0]  dark_thr;
    logic [LevelW-1:0]  light_thr;
    logic [DebW-1:0]    debounce;
    logic [TickW-1:0]   on_ticks;
    logic [MinuteW-1:0] off_time;
    logic [TickW-1:0]   max_cool;
  } cfg_t;

  typedef struct packed {
    logic              lamp_on;
    logic              indicator;
    logic [PhaseW-1:0] phase;
  } res_t;

endpackage

// ===== rtl/dtl_cfg.sv =====
// ----------------------------------------------------------------------------
// dtl_cfg
// configuration registers, on duration kept as a tick count
// ----------------------------------------------------------------------------
module dtl_cfg #(
  parameter int TICK_SECONDS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [dtl_pkg::CfgIdxW-1:0]   wr_idx,
  input  logic [dtl_pkg::CfgDataW-1:0]  wr_data,
  output dtl_pkg::cfg_t                 cfg
);
  import dtl_pkg::*;

  // minutes * 60 / TICK_SECONDS as one multiply by a scaled reciprocal
  localparam int      RecipShift = 22;
  localparam longint  RecipMul   = ((64'd1 << RecipShift) + TICK_SECONDS - 1) / TICK_SECONDS;
  localparam longint  ScaledMul  = 60 * RecipMul;
  localparam int      MulW       = 29;
  localparam int      ProdW      = DurW + MulW;
  localparam logic [MulW-1:0]  SCALED_V  = MulW'(ScaledMul);
  localparam logic [TickW-1:0] ON_TICKS0 = TickW'(RST_ON_DUR * 60 / TICK_SECONDS);

  cfg_t             cfg_r;
  cfg_t             cfg_nxt;
  logic [ProdW-1:0] prod;

  assign prod = ProdW'(wr_data[DurW-1:0]) * ProdW'(SCALED_V);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_idx)
        REG_DARK_THR:  cfg_nxt.dark_thr  = wr_data[LevelW-1:0];
        REG_LIGHT_THR: cfg_nxt.light_thr = wr_data[LevelW-1:0];
        REG_DEBOUNCE:  cfg_nxt.debounce  = wr_data[DebW-1:0];
        REG_ON_DUR:    cfg_nxt.on_ticks  = prod[RecipShift +: TickW];
        REG_OFF_TIME:  cfg_nxt.off_time  = wr_data[MinuteW-1:0];
        REG_MAX_COOL:  cfg_nxt.max_cool  = wr_data[TickW-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dark_thr  <= RST_DARK_THR;
      cfg_r.light_thr <= RST_LIGHT_THR;
      cfg_r.debounce  <= RST_DEBOUNCE;
      cfg_r.on_ticks  <= ON_TICKS0;
      cfg_r.off_time  <= RST_OFF_TIME;
      cfg_r.max_cool  <= RST_MAX_COOL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/dtl_debounce.sv =====
// ----------------------------------------------------------------------------
// dtl_debounce
// dark and light streak counters and the debounced dark flag
// ----------------------------------------------------------------------------
module dtl_debounce (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic [dtl_pkg::LevelW-1:0]  level,
  input  dtl_pkg::cfg_t               cfg,
  output logic                        dark_nxt
);
  import dtl_pkg::*;

  logic [DebW-1:0] dark_run_r, dark_run_nxt;
  logic [DebW-1:0] light_run_r, light_run_nxt;
  logic            dark_flag_r;
  logic            is_dark, is_light;

  assign is_dark  = (level <= cfg.dark_thr);
  assign is_light = (level >= cfg.light_thr);

  always_comb begin
    dark_run_nxt  = '0;
    light_run_nxt = '0;
    if (is_dark) begin
      dark_run_nxt = (dark_run_r == RUN_MAX) ? RUN_MAX : dark_run_r + 1'b1;
    end else if (is_light) begin
      light_run_nxt = (light_run_r == RUN_MAX) ? RUN_MAX : light_run_r + 1'b1;
    end
    if (dark_run_nxt >= cfg.debounce) begin
      dark_nxt = 1'b1;
    end else if (light_run_nxt >= cfg.debounce) begin
      dark_nxt = 1'b0;
    end else begin
      dark_nxt = dark_flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_run_r  <= '0;
      light_run_r <= '0;
      dark_flag_r <= 1'b0;
    end else if (en) begin
      dark_run_r  <= dark_run_nxt;
      light_run_r <= light_run_nxt;
      dark_flag_r <= dark_nxt;
    end
  end

endmodule

// ===== rtl/dtl_phase.sv =====
// ----------------------------------------------------------------------------
// dtl_phase
// idle, on and cooldown sequencing with tick counter and on limit
// ----------------------------------------------------------------------------
module dtl_phase (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         dark,
  input  logic [dtl_pkg::MinuteW-1:0]  minute,
  input  dtl_pkg::cfg_t                cfg,
  output dtl_pkg::res_t                res
);
  import dtl_pkg::*;

  typedef enum logic [PhaseW-1:0] {
    ST_IDLE = PH_IDLE,
    ST_ON   = PH_ON,
    ST_COOL = PH_COOL
  } state_t;

  state_t           state_r, state_nxt;
  logic [TickW-1:0] tick_r, tick_nxt;
  logic [TickW-1:0] limit_r, limit_nxt;
  logic [TickW-1:0] tick_inc;

  assign tick_inc = (tick_r == TICK_MAX) ? TICK_MAX : tick_r + 1'b1;

  always_comb begin
    state_nxt = state_r;
    tick_nxt  = tick_r;
    limit_nxt = limit_r;
    case (state_r)
      ST_ON: begin
        tick_nxt = tick_inc;
        if (tick_inc >= limit_r || minute >= cfg.off_time) begin
          state_nxt = ST_COOL;
          tick_nxt  = '0;
        end
      end
      ST_COOL: begin
        tick_nxt = tick_inc;
        if (!dark || tick_inc >= cfg.max_cool) begin
          state_nxt = ST_IDLE;
          tick_nxt  = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        if (dark) begin
          state_nxt = ST_ON;
          tick_nxt  = '0;
          limit_nxt = cfg.on_ticks;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tick_r  <= '0;
      limit_r <= '0;
    end else if (en) begin
      state_r <= state_nxt;
      tick_r  <= tick_nxt;
      limit_r <= limit_nxt;
    end
  end

  assign res.lamp_on   = (state_nxt == ST_ON);
  assign res.indicator = dark && (state_nxt == ST_IDLE);
  assign res.phase     = state_nxt;

endmodule

// ===== rtl/dusk_timed_light_controller.sv =====
// path: input register then result register; the result register takes a tick once
// no stalled result is held, and the result stays on the outputs until out_ready
// throughput: one tick per cycle when not stalled; streak, flag and phase update in
// one pass per cycle; the on limit is worked out from the duration register on write
// reset: synchronous, active low; state idle, streaks and counters zero,
// registers at their default values, both pipeline registers empty
// ----------------------------------------------------------------------------
// dusk_timed_light_controller
// dusk timed lamp controller, one light sample and time of day per tick
// ----------------------------------------------------------------------------
module dusk_timed_light_controller #(
  parameter int TICK_SECONDS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dtl_pkg::LevelW-1:0]    in_light_level,
  input  logic [dtl_pkg::MinuteW-1:0]   in_minute_of_day,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_lamp_on,
  output logic                          out_indicator,
  output logic [dtl_pkg::PhaseW-1:0]    out_phase,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dtl_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dtl_pkg::CfgDataW-1:0]  cfg_data
);
  import dtl_pkg::*;

  cfg_t               cfg;
  res_t               res;
  res_t               res_r;
  logic               in_valid_r;
  logic               out_valid_r;
  logic [LevelW-1:0]  level_r;
  logic [MinuteW-1:0] minute_r;
  logic               adv;
  logic               dark_nxt;

  assign cfg_ready = 1'b1;
  assign adv       = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;

  dtl_cfg #(.TICK_SECONDS(TICK_SECONDS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  dtl_debounce u_debounce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .level    (level_r),
    .cfg      (cfg),
    .dark_nxt (dark_nxt)
  );

  dtl_phase u_phase (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .dark   (dark_nxt),
    .minute (minute_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      level_r  <= in_light_level;
      minute_r <= in_minute_of_day;
    end
    if (adv) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_lamp_on   = res_r.lamp_on;
  assign out_indicator = res_r.indicator;
  assign out_phase     = res_r.phase;

endmodule

// ===== rtl/dtl_checker.sv =====
// ----------------------------------------------------------------------------
// dtl_checker
// port level checks of the dusk timed light controller
// ----------------------------------------------------------------------------
module dtl_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_lamp_on,
  input logic                        out_indicator,
  input logic [dtl_pkg::PhaseW-1:0]  out_phase
);
  import dtl_pkg::*;

  a_relay_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lamp_on == (out_phase == PH_ON)))
    else $error("relay does not match on phase");

  a_ind_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_indicator) |-> (out_phase == PH_IDLE))
    else $error("indicator outside idle phase");

  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_phase != 2'd3))
    else $error("unused phase code on output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_lamp_on)
      && $stable(out_indicator) && $stable(out_phase)))
    else $error("stalled result transfer changed");

endmodule

bind dusk_timed_light_controller dtl_checker u_dtl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_lamp_on   (out_lamp_on),
  .out_indicator (out_indicator),
  .out_phase     (out_phase)
);

// ===== tb/tb_dusk_timed_light_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dusk_timed_light_controller
// checks the dusk lamp controller tick by tick against a local predictor of
// streak debounce, dark flag and the idle/on/cooldown phase machine, under
// directed corner cases, randomized register settings and output back-pressure
// ----------------------------------------------------------------------------
module tb_dusk_timed_light_controller;
  import dtl_pkg::*;

  localparam int TICK_SECONDS = 8;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 6;
  localparam int MAX_REPORTS  = 10;

  localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;

  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;
  localparam int RX_SPARSE  = 3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [LevelW-1:0]   in_light_level = '0;
  logic [MinuteW-1:0]  in_minute_of_day = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_lamp_on;
  logic                out_indicator;
  logic [PhaseW-1:0]   out_phase;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // register copies
  logic [LevelW-1:0]  thr_dark   = RST_DARK_THR;
  logic [LevelW-1:0]  thr_light  = RST_LIGHT_THR;
  logic [DebW-1:0]    deb_len    = RST_DEBOUNCE;
  logic [DurW-1:0]    on_minutes = DurW'(RST_ON_DUR);
  logic [MinuteW-1:0] off_minute = RST_OFF_TIME;
  logic [TickW-1:0]   cool_limit = RST_MAX_COOL;

  // predicted controller state
  logic [DebW-1:0]    dark_streak  = '0;
  logic [DebW-1:0]    light_streak = '0;
  logic               is_dark      = 1'b0;
  logic [PhaseW-1:0]  lamp_phase   = PH_IDLE;
  logic [TickW-1:0]   phase_ticks  = '0;
  logic [TickW-1:0]   on_tick_cap  = '0;

  res_t        queued_lamp_states[$];
  int unsigned err_count = 0;
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;
  int unsigned rx_mode = RX_ALWAYS;
  int unsigned rx_cycle = 0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  dusk_timed_light_controller #(
    .TICK_SECONDS(TICK_SECONDS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_light_level   (in_light_level),
    .in_minute_of_day (in_minute_of_day),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_lamp_on      (out_lamp_on),
    .out_indicator    (out_indicator),
    .out_phase        (out_phase),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    case (idx)
      REG_DARK_THR:  thr_dark   = data[LevelW-1:0];
      REG_LIGHT_THR: thr_light  = data[LevelW-1:0];
      REG_DEBOUNCE:  deb_len    = data[DebW-1:0];
      REG_ON_DUR:    on_minutes = data[DurW-1:0];
      REG_OFF_TIME:  off_minute = data[MinuteW-1:0];
      REG_MAX_COOL:  cool_limit = data[TickW-1:0];
      default: ;
    endcase
  endfunction

  function automatic res_t predict_lamp_tick(input logic [LevelW-1:0] level,
                                             input logic [MinuteW-1:0] minute);
    res_t r;
    if (level <= thr_dark) begin
      if (dark_streak != RUN_MAX) dark_streak++;
      light_streak = '0;
    end else if (level >= thr_light) begin
      if (light_streak != RUN_MAX) light_streak++;
      dark_streak = '0;
    end else begin
      dark_streak  = '0;
      light_streak = '0;
    end
    if (dark_streak >= deb_len) is_dark = 1'b1;
    else if (light_streak >= deb_len) is_dark = 1'b0;
    case (lamp_phase)
      PH_ON: begin
        if (phase_ticks != TICK_MAX) phase_ticks++;
        if (phase_ticks >= on_tick_cap || minute >= off_minute) begin
          lamp_phase  = PH_COOL;
          phase_ticks = '0;
        end
      end
      PH_COOL: begin
        if (phase_ticks != TICK_MAX) phase_ticks++;
        if (!is_dark || phase_ticks >= cool_limit) begin
          lamp_phase  = PH_IDLE;
          phase_ticks = '0;
        end
      end
      default: begin
        lamp_phase = PH_IDLE;
        if (is_dark) begin
          lamp_phase  = PH_ON;
          phase_ticks = '0;
          on_tick_cap = TickW'((int'(on_minutes) * 60) / TICK_SECONDS);
        end
      end
    endcase
    r.lamp_on   = (lamp_phase == PH_ON);
    r.indicator = is_dark && (lamp_phase == PH_IDLE);
    r.phase     = lamp_phase;
    return r;
  endfunction

  function automatic logic [MinuteW-1:0] pick_minute();
    if ($urandom_range(99, 0) < 85 && off_minute != 0) begin
      return MinuteW'($urandom_range(off_minute - 1, 0));
    end
    return MinuteW'($urandom_range(11'h7FF, off_minute));
  endfunction

  task automatic send_tick(input logic [LevelW-1:0] level, input logic [MinuteW-1:0] minute);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid         <= 1'b1;
    in_light_level   <= level;
    in_minute_of_day <= minute;
    do @(posedge clk); while (!in_ready);
    queued_lamp_states.push_back(predict_lamp_tick(level, minute));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (queued_lamp_states.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic load_regs(input logic [CfgDataW-1:0] dark, input logic [CfgDataW-1:0] light,
                           input logic [CfgDataW-1:0] deb, input logic [CfgDataW-1:0] dur,
                           input logic [CfgDataW-1:0] off, input logic [CfgDataW-1:0] cool);
    write_reg(REG_DARK_THR, dark, 1'b0);
    write_reg(REG_LIGHT_THR, light, 1'b0);
    write_reg(REG_DEBOUNCE, deb, 1'b0);
    write_reg(REG_ON_DUR, dur, 1'b0);
    write_reg(REG_OFF_TIME, off, 1'b0);
    write_reg(REG_MAX_COOL, cool, 1'b1);
  endtask

  // streaks of dark or light samples with random content, plus noise and broken streaks
  task automatic run_mixed_ticks(input int unsigned count);
    int unsigned sent;
    int unsigned kind;
    int unsigned run_len;
    logic [LevelW-1:0] level;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99, 0);
      run_len = (kind < 70) ? $urandom_range(deb_len + 4, 1) : $urandom_range(4, 1);
      repeat (run_len) begin
        if (kind < 35) begin
          level = LevelW'($urandom_range(thr_dark, 0));
        end else if (kind < 70) begin
          level = LevelW'($urandom_range(10'h3FF, thr_light));
        end else if (kind < 85 && thr_light > thr_dark + 1) begin
          level = LevelW'($urandom_range(thr_light - 1, thr_dark + 1));
        end else begin
          level = LevelW'($urandom_range(10'h3FF, 0));
        end
        send_tick(level, pick_minute());
        sent++;
      end
    end
  endtask

  task automatic test_debounce_and_phases();
    gap_max = 3;
    rx_mode <= RX_RANDOM;
    send_tick(10'd0, 11'd0);
    send_tick(10'd150, 11'd100);
    send_tick(10'd150, 11'd200);
    send_tick(10'd150, 11'd300);
    send_tick(10'd151, 11'd1379);
    send_tick(10'd1023, 11'd1380);
    send_tick(10'd500, 11'd1439);
    send_tick(10'd600, 11'd2047);
    send_tick(10'd1023, 11'd60);
    send_tick(10'd499, 11'd1000);
    wait_drained();
  endtask

  task automatic test_special_settings();
    gap_max = 0;
    rx_mode <= RX_ALWAYS;
    // unused indexes must leave every register alone
    write_reg(REG_SPARE_LO, 16'hFFFF, 1'b0);
    write_reg(REG_SPARE_HI, 16'hFFFF, 1'b0);
    // overlapping thresholds, dark wins
    write_reg(REG_DARK_THR, 16'd600, 1'b0);
    write_reg(REG_LIGHT_THR, 16'd400, 1'b0);
    write_reg(REG_DEBOUNCE, 16'd1, 1'b1);
    send_tick(10'd500, 11'd2047);
    send_tick(10'd1023, 11'd0);
    wait_drained();
    write_reg(REG_OFF_TIME, 16'd0, 1'b1);
    send_tick(10'd200, 11'd0);
    send_tick(10'd1023, 11'd5);
    wait_drained();
    // zero debounce and zero limits cycle the phases every tick
    write_reg(REG_DEBOUNCE, 16'd0, 1'b0);
    write_reg(REG_ON_DUR, 16'd0, 1'b0);
    write_reg(REG_MAX_COOL, 16'd0, 1'b1);
    repeat (4) send_tick(10'd1023, 11'd7);
    wait_drained();
  endtask

  task automatic test_random_settings();
    logic [CfgDataW-1:0] dark;
    logic [CfgDataW-1:0] light;
    logic [CfgDataW-1:0] deb;
    for (int s = 0; s < 8; s++) begin
      wait_drained();
      case (s)
        0: load_regs(RST_DARK_THR, RST_LIGHT_THR, RST_DEBOUNCE, 16'd2, RST_OFF_TIME, 16'd30);
        1: load_regs('1, '1, '1, '1, '1, '1);
        2: load_regs('0, '0, '0, '0, '0, '0);
        3: load_regs(16'd0, 16'd1023, 16'd1, 16'd30, 16'd1439, 16'd1);
        4: load_regs(16'd300, 16'd700, 16'd15, 16'd1, 16'd720, 16'd65535);
        default: begin
          dark  = 16'($urandom_range(400, 20));
          light = 16'(dark + $urandom_range(400, 1));
          deb   = ($urandom_range(9, 0) == 0) ? 16'd0 : 16'($urandom_range(6, 1));
          load_regs(dark, light, deb, 16'($urandom_range(6, 0)),
                    16'($urandom_range(2047, 0)), 16'($urandom_range(60, 1)));
        end
      endcase
      gap_max = (s % 3 == 0) ? 0 : ((s % 3 == 1) ? 3 : 8);
      rx_mode <= s % 4;
      run_mixed_ticks(220);
    end
    wait_drained();
  endtask

  task automatic test_output_hold();
    load_regs(16'd200, 16'd600, 16'd3, 16'd2, 16'd1200, 16'd20);
    gap_max = 0;
    rx_mode <= RX_ALWAYS;
    hold_req <= hold_req + 1;
    run_mixed_ticks(120);
    wait_drained();
  endtask

  task automatic check_result();
    res_t want;
    res_t got;
    got.lamp_on   = out_lamp_on;
    got.indicator = out_indicator;
    got.phase     = out_phase;
    if (queued_lamp_states.size() == 0) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: unexpected transfer lamp=%0b indicator=%0b phase=%0d",
                 $time, got.lamp_on, got.indicator, got.phase);
    end else begin
      want = queued_lamp_states.pop_front();
      if (got.lamp_on !== want.lamp_on || got.indicator !== want.indicator ||
          got.phase !== want.phase) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: mismatch lamp exp %0b got %0b, ind exp %0b got %0b, phase exp %0d got %0d",
                   $time, want.lamp_on, got.lamp_on, want.indicator, got.indicator,
                   want.phase, got.phase);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_RANDOM:  out_ready <= ($urandom_range(3, 0) != 0);
        RX_PATTERN: out_ready <= ((rx_cycle % 7) < 4);
        RX_SPARSE:  out_ready <= ($urandom_range(3, 0) == 0);
        default:    out_ready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_debounce_and_phases();
    test_special_settings();
    test_random_settings();
    test_output_hold();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== dusk_timed_light_controller.f =====
rtl/dtl_pkg.sv
rtl/dtl_cfg.sv
rtl/dtl_debounce.sv
rtl/dtl_phase.sv
rtl/dusk_timed_light_controller.sv
rtl/dtl_checker.sv
tb/tb_dusk_timed_light_controller.sv
